// ===== rtl/kline_block_link_engine_assert.svh =====
// Assertion macros for the block's RTL
`ifndef KLINE_BLOCK_LINK_ENGINE_ASSERT_SVH
`define KLINE_BLOCK_LINK_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define KBLE_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("kble assertion failed");

// Next-cycle implication, checked outside reset
`define KBLE_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("kble assertion failed");

`endif

// ===== rtl/kble_pkg.sv =====
package kble_pkg;

    // Line protocol bytes
    localparam logic [7:0] BYTE_SYNC  = 8'h81;
    localparam logic [7:0] BYTE_START = 8'h0D;
    localparam logic [7:0] BYTE_END   = 8'h03;

    // Request length limits
    localparam logic [2:0] REQ_LEN_MIN = 3'd3;
    localparam logic [2:0] REQ_LEN_MAX = 3'd6;

    // Request byte positions
    localparam logic [2:0] REQ_IDX_LENGTH  = 3'd0;
    localparam logic [2:0] REQ_IDX_COUNTER = 3'd1;
    localparam logic [2:0] REQ_IDX_TITLE   = 3'd2;
    localparam logic [2:0] REQ_IDX_DATA_A  = 3'd3;
    localparam logic [2:0] REQ_IDX_DATA_B  = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_REQ_LENGTH = 3'd0;
    localparam logic [2:0] CFG_REQ_TITLE  = 3'd1;
    localparam logic [2:0] CFG_REQ_DATA_A = 3'd2;
    localparam logic [2:0] CFG_REQ_DATA_B = 3'd3;
    localparam logic [2:0] CFG_REQ_DATA_C = 3'd4;

    // Link phase, one-hot
    typedef enum logic [3:0] {
        PH_START      = 4'b0001,
        PH_RECEIVE    = 4'b0010,
        PH_SEND       = 4'b0100,
        PH_CLOSE_ECHO = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [2:0] req_length;
        logic [7:0] req_title;
        logic [7:0] req_data_a;
        logic [7:0] req_data_b;
        logic [7:0] req_data_c;
    } cfg_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] byte_pos;
        logic [7:0] ann_length;
        logic [7:0] seq_count;
        logic [7:0] last_title;
        logic       drop_echo;
        logic [7:0] pending;
    } state_t;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic       block_done;
        logic [7:0] block_title;
        logic [7:0] block_counter;
        logic       request_sent;
        logic       framing_error;
        logic       link_up;
    } result_t;

    // Request length clamped to the supported range
    function automatic logic [2:0] eff_length(input logic [2:0] len);
        logic [2:0] res;
        res = len;
        if (len < REQ_LEN_MIN) res = REQ_LEN_MIN;
        else if (len > REQ_LEN_MAX) res = REQ_LEN_MAX;
        return res;
    endfunction

    // Byte of the outgoing request block at a given position
    function automatic logic [7:0] request_byte(input logic [2:0] idx, input cfg_t cfg,
                                                input logic [7:0] seq);
        logic [2:0] len;
        logic [7:0] res;
        len = eff_length(cfg.req_length);
        priority if (idx >= len)              res = BYTE_END;
        else if (idx == REQ_IDX_LENGTH)       res = {5'd0, len};
        else if (idx == REQ_IDX_COUNTER)      res = seq + 8'd1;
        else if (idx == REQ_IDX_TITLE)        res = cfg.req_title;
        else if (idx == REQ_IDX_DATA_A)       res = cfg.req_data_a;
        else if (idx == REQ_IDX_DATA_B)       res = cfg.req_data_b;
        else                                  res = cfg.req_data_c;
        return res;
    endfunction

endpackage

// ===== rtl/kble_step.sv =====
// Per-byte link logic: next state and result for one received line byte
module kble_step (
    input  kble_pkg::state_t  state,
    input  kble_pkg::cfg_t    cfg,
    input  logic [7:0]        line_byte,
    output kble_pkg::state_t  state_next,
    output kble_pkg::result_t result
);

    logic [7:0] len_cur;
    logic [7:0] pos_inc;
    logic [2:0] send_pos;
    logic [2:0] req_len;

    assign len_cur  = (state.byte_pos == 8'd0) ? line_byte : state.ann_length;
    assign pos_inc  = state.byte_pos + 8'd1;
    assign send_pos = pos_inc[2:0];
    assign req_len  = kble_pkg::eff_length(cfg.req_length);

    always_comb
    begin
        state_next = state;
        result     = '0;

        unique case (state.phase)
            kble_pkg::PH_START:
            begin
                if (line_byte == kble_pkg::BYTE_SYNC)
                begin
                    result.send_valid = 1'b1;
                    result.send_byte  = ~line_byte;
                end
                else if (line_byte == kble_pkg::BYTE_START)
                begin
                    state_next.phase     = kble_pkg::PH_RECEIVE;
                    state_next.byte_pos  = 8'd0;
                    state_next.drop_echo = 1'b0;
                end
            end

            kble_pkg::PH_RECEIVE:
            begin
                if (state.drop_echo)
                begin
                    // own echo of the complement just sent
                    state_next.drop_echo = 1'b0;
                end
                else
                begin
                    if (state.byte_pos == 8'd0) state_next.ann_length = line_byte;
                    if (state.byte_pos > len_cur)
                    begin
                        // overrun: discard and restart reception
                        result.framing_error = 1'b1;
                        state_next.byte_pos  = 8'd0;
                    end
                    else
                    begin
                        if (state.byte_pos == 8'd1) state_next.seq_count = line_byte;
                        if (state.byte_pos == 8'd2) state_next.last_title = line_byte;
                        result.payload_valid = 1'b1;
                        result.payload_byte  = line_byte;
                        result.payload_index = state.byte_pos;
                        if (line_byte == kble_pkg::BYTE_END && state.byte_pos == len_cur)
                        begin
                            // block closed: start the request with its length byte
                            result.block_done   = 1'b1;
                            state_next.byte_pos = 8'd0;
                            state_next.pending  = {5'd0, req_len};
                            result.send_valid   = 1'b1;
                            result.send_byte    = {5'd0, req_len};
                            state_next.phase    = kble_pkg::PH_SEND;
                        end
                        else
                        begin
                            result.send_valid    = 1'b1;
                            result.send_byte     = ~line_byte;
                            state_next.drop_echo = 1'b1;
                            state_next.byte_pos  = pos_inc;
                        end
                    end
                end
            end

            kble_pkg::PH_SEND:
            begin
                // advance once the partner complements the pending byte
                if (line_byte == ~state.pending)
                begin
                    state_next.byte_pos = {5'd0, send_pos};
                    if (send_pos >= req_len)
                    begin
                        state_next.pending = kble_pkg::BYTE_END;
                        state_next.phase   = kble_pkg::PH_CLOSE_ECHO;
                        result.send_byte   = kble_pkg::BYTE_END;
                    end
                    else
                    begin
                        state_next.pending = kble_pkg::request_byte(send_pos, cfg,
                                                                     state.seq_count);
                        result.send_byte   = kble_pkg::request_byte(send_pos, cfg,
                                                                     state.seq_count);
                    end
                    result.send_valid = 1'b1;
                end
            end

            kble_pkg::PH_CLOSE_ECHO:
            begin
                if (line_byte == kble_pkg::BYTE_END)
                begin
                    result.request_sent  = 1'b1;
                    state_next.phase     = kble_pkg::PH_RECEIVE;
                    state_next.byte_pos  = 8'd0;
                    state_next.drop_echo = 1'b0;
                end
            end

            default:
            begin
                state_next = state;
            end
        endcase

        result.block_title   = state_next.last_title;
        result.block_counter = state_next.seq_count;
        result.link_up       = (state_next.phase != kble_pkg::PH_START);
    end

endmodule

// ===== rtl/kline_block_link_engine.sv =====
// K-line block link engine, tester side.
// Input channel (in_valid/in_ready/line_byte) carries every byte heard on the
// line, own echoes included. Each accepted byte yields exactly one result on
// the output channel (out_valid/out_ready plus the result fields): a byte to
// transmit if send_valid, a received block byte if payload_valid, and status.
// The result is registered and appears in the cycle after the input
// transfer. Throughput: one byte per cycle while the receiver takes results;
// the per-byte state update and result decode are a single compare-and-select stage.
// in_ready is high while the result register is empty or being taken in the
// same cycle, so a stalled receiver holds the result and stalls the input
// after one byte; nothing is dropped.
// Configuration (cfg_we/cfg_index/cfg_data) writes the request registers;
// write only while the block is idle.
// Reset: link returns to the start phase waiting for 0x81/0x0D, counters and
// captured fields clear, request registers take their defaults, no result
// is pending.
module kline_block_link_engine (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] line_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       send_valid,
    output logic [7:0] send_byte,
    output logic       payload_valid,
    output logic [7:0] payload_byte,
    output logic [7:0] payload_index,
    output logic       block_done,
    output logic [7:0] block_title,
    output logic [7:0] block_counter,
    output logic       request_sent,
    output logic       framing_error,
    output logic       link_up,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    `include "kline_block_link_engine_assert.svh"

    kble_pkg::cfg_t    cfg_reg;
    kble_pkg::state_t  state_reg;
    kble_pkg::state_t  state_next;
    kble_pkg::result_t res_reg;
    kble_pkg::result_t res_next;
    logic              out_valid_reg;
    logic              in_xfer;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.req_length <= 3'd3;
            cfg_reg.req_title  <= 8'd9;
            cfg_reg.req_data_a <= 8'd0;
            cfg_reg.req_data_b <= 8'd0;
            cfg_reg.req_data_c <= 8'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kble_pkg::CFG_REQ_LENGTH: cfg_reg.req_length <= cfg_data[2:0];
                kble_pkg::CFG_REQ_TITLE:  cfg_reg.req_title  <= cfg_data;
                kble_pkg::CFG_REQ_DATA_A: cfg_reg.req_data_a <= cfg_data;
                kble_pkg::CFG_REQ_DATA_B: cfg_reg.req_data_b <= cfg_data;
                kble_pkg::CFG_REQ_DATA_C: cfg_reg.req_data_c <= cfg_data;
                default:                  cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // Per-byte logic
    kble_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .line_byte  (line_byte),
        .state_next (state_next),
        .result     (res_next)
    );

    // Link state, updated on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= kble_pkg::PH_START;
            state_reg.byte_pos   <= 8'd0;
            state_reg.ann_length <= 8'd0;
            state_reg.seq_count  <= 8'd0;
            state_reg.last_title <= 8'd0;
            state_reg.drop_echo  <= 1'b0;
            state_reg.pending    <= 8'd0;
        end
        else if (in_xfer)
        begin
            state_reg <= state_next;
        end
    end

    // Result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign send_valid    = res_reg.send_valid;
    assign send_byte     = res_reg.send_byte;
    assign payload_valid = res_reg.payload_valid;
    assign payload_byte  = res_reg.payload_byte;
    assign payload_index = res_reg.payload_index;
    assign block_done    = res_reg.block_done;
    assign block_title   = res_reg.block_title;
    assign block_counter = res_reg.block_counter;
    assign request_sent  = res_reg.request_sent;
    assign framing_error = res_reg.framing_error;
    assign link_up       = res_reg.link_up;

    // Checks
    `KBLE_ASSERT_NEXT(a_xfer_gives_result, in_xfer, out_valid_reg)
    `KBLE_ASSERT_NOW(a_done_starts_send, out_valid_reg && res_reg.block_done,
                     res_reg.send_valid && state_reg.phase == kble_pkg::PH_SEND)
    `KBLE_ASSERT_NOW(a_sent_back_to_rx, out_valid_reg && res_reg.request_sent,
                     state_reg.phase == kble_pkg::PH_RECEIVE && state_reg.byte_pos == 8'd0)
    `KBLE_ASSERT_NOW(a_frame_err_no_data, out_valid_reg && res_reg.framing_error,
                     !res_reg.payload_valid && !res_reg.send_valid)

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int STALL_LIMIT = 2000;
    localparam int RUN_ITEMS   = 550;

    // Tester-side link state, one copy for stimulus planning and one for checking
    typedef struct {
        kble_pkg::phase_t phase;
        logic [7:0]       pos;
        logic [7:0]       len;
        logic [7:0]       seq;
        logic [7:0]       title;
        logic             skip;
        logic [7:0]       pending;
    } link_model_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] line_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       block_done;
    logic [7:0] block_title;
    logic [7:0] block_counter;
    logic       request_sent;
    logic       framing_error;
    logic       link_up;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_index = 3'd0;
    logic [7:0] cfg_data = 8'h00;

    // Request register shadows, reset values
    logic [2:0] cfg_len   = 3'd3;
    logic [7:0] cfg_title = 8'd9;
    logic [7:0] cfg_a     = 8'd0;
    logic [7:0] cfg_b     = 8'd0;
    logic [7:0] cfg_c     = 8'd0;

    link_model_t       plan_m;
    link_model_t       chk_m;
    logic [7:0]        heard_bytes[$];
    kble_pkg::result_t due_results[$];

    int  n_pushed = 0;
    int  n_taken = 0;
    int  n_results = 0;
    int  errors = 0;
    int  n_blocks = 0;
    int  n_requests = 0;
    int  n_overruns = 0;
    int  stall_cycles = 0;
    bit  byte_taken = 1'b0;
    int  hold_left = 0;
    bit  held_once = 1'b0;

    kline_block_link_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .line_byte     (line_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .send_valid    (send_valid),
        .send_byte     (send_byte),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .payload_index (payload_index),
        .block_done    (block_done),
        .block_title   (block_title),
        .block_counter (block_counter),
        .request_sent  (request_sent),
        .framing_error (framing_error),
        .link_up       (link_up),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic link_model_t fresh_link();
        link_model_t m;
        m.phase   = kble_pkg::PH_START;
        m.pos     = 8'd0;
        m.len     = 8'd0;
        m.seq     = 8'd0;
        m.title   = 8'd0;
        m.skip    = 1'b0;
        m.pending = 8'd0;
        return m;
    endfunction

    // Request length as the block uses it, clamped to three..six
    function automatic logic [2:0] req_len_eff();
        if (cfg_len < 3'd3)
            return 3'd3;
        if (cfg_len > 3'd6)
            return 3'd6;
        return cfg_len;
    endfunction

    function automatic logic [7:0] request_at(input logic [2:0] idx, input logic [7:0] seq);
        logic [2:0] n;
        n = req_len_eff();
        if (idx >= n)
            return kble_pkg::BYTE_END;
        unique case (idx)
            kble_pkg::REQ_IDX_LENGTH:  return {5'd0, n};
            kble_pkg::REQ_IDX_COUNTER: return seq + 8'd1;
            kble_pkg::REQ_IDX_TITLE:   return cfg_title;
            kble_pkg::REQ_IDX_DATA_A:  return cfg_a;
            kble_pkg::REQ_IDX_DATA_B:  return cfg_b;
            default:                   return cfg_c;
        endcase
    endfunction

    // One line byte through the link: updates the state, returns the result
    function automatic kble_pkg::result_t step_link(inout link_model_t m,
                                                    input logic [7:0] b);
        kble_pkg::result_t r;
        r = '0;
        unique case (m.phase)
            kble_pkg::PH_START:
            begin
                if (b == kble_pkg::BYTE_SYNC)
                begin
                    r.send_valid = 1'b1;
                    r.send_byte  = ~b;
                end
                else if (b == kble_pkg::BYTE_START)
                begin
                    m.phase = kble_pkg::PH_RECEIVE;
                    m.pos   = 8'd0;
                    m.skip  = 1'b0;
                end
            end
            kble_pkg::PH_RECEIVE:
            begin
                if (m.skip)
                    m.skip = 1'b0;
                else
                begin
                    if (m.pos == 8'd0)
                        m.len = b;
                    if (m.pos > m.len)
                    begin
                        r.framing_error = 1'b1;
                        m.pos = 8'd0;
                    end
                    else
                    begin
                        if (m.pos == 8'd1)
                            m.seq = b;
                        if (m.pos == 8'd2)
                            m.title = b;
                        r.payload_valid = 1'b1;
                        r.payload_byte  = b;
                        r.payload_index = m.pos;
                        if (b == kble_pkg::BYTE_END && m.pos == m.len)
                        begin
                            r.block_done = 1'b1;
                            m.pos     = 8'd0;
                            m.pending = request_at(kble_pkg::REQ_IDX_LENGTH, m.seq);
                            m.phase   = kble_pkg::PH_SEND;
                            r.send_valid = 1'b1;
                            r.send_byte  = m.pending;
                        end
                        else
                        begin
                            r.send_valid = 1'b1;
                            r.send_byte  = ~b;
                            m.skip = 1'b1;
                            m.pos  = m.pos + 8'd1;
                        end
                    end
                end
            end
            kble_pkg::PH_SEND:
            begin
                if (b == ~m.pending)
                begin
                    m.pos = (m.pos + 8'd1) & 8'h07;
                    if (m.pos >= {5'd0, req_len_eff()})
                    begin
                        m.pending = kble_pkg::BYTE_END;
                        m.phase   = kble_pkg::PH_CLOSE_ECHO;
                    end
                    else
                        m.pending = request_at(m.pos[2:0], m.seq);
                    r.send_valid = 1'b1;
                    r.send_byte  = m.pending;
                end
            end
            default:
            begin
                if (b == kble_pkg::BYTE_END)
                begin
                    r.request_sent = 1'b1;
                    m.phase = kble_pkg::PH_RECEIVE;
                    m.pos   = 8'd0;
                    m.skip  = 1'b0;
                end
            end
        endcase
        r.block_title   = m.title;
        r.block_counter = m.seq;
        r.link_up       = (m.phase != kble_pkg::PH_START);
        return r;
    endfunction

    function automatic string show(input kble_pkg::result_t r);
        return $sformatf({"send %0b/%02h pay %0b/%02h@%0d done %0b title %02h",
                          " cnt %02h sent %0b ferr %0b up %0b"},
                         r.send_valid, r.send_byte, r.payload_valid, r.payload_byte,
                         r.payload_index, r.block_done, r.block_title, r.block_counter,
                         r.request_sent, r.framing_error, r.link_up);
    endfunction

    function automatic bit no_gaps();
        return n_taken >= 100 && n_taken < 220;
    endfunction

    function automatic logic [7:0] other_than(input logic [7:0] x);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == x)
            b = b + 8'd1;
        return b;
    endfunction

    function automatic logic [7:0] edge_byte();
        unique case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Queue a byte for the line and track where the link will be after it
    function automatic void push_byte(input logic [7:0] b);
        heard_bytes.push_back(b);
        n_pushed++;
        void'(step_link(plan_m, b));
    endfunction

    // Wait until every byte is taken and every result seen
    task automatic wait_idle();
        do
            @(negedge clk);
        while (n_taken != n_pushed || n_results != n_taken);
        repeat (2) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        unique case (idx)
            kble_pkg::CFG_REQ_LENGTH: cfg_len   = data[2:0];
            kble_pkg::CFG_REQ_TITLE:  cfg_title = data;
            kble_pkg::CFG_REQ_DATA_A: cfg_a     = data;
            kble_pkg::CFG_REQ_DATA_B: cfg_b     = data;
            kble_pkg::CFG_REQ_DATA_C: cfg_c     = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_setup();
        write_reg(kble_pkg::CFG_REQ_LENGTH, 8'($urandom_range(0, 7)));
        write_reg(kble_pkg::CFG_REQ_TITLE, edge_byte());
        write_reg(kble_pkg::CFG_REQ_DATA_A, edge_byte());
        write_reg(kble_pkg::CFG_REQ_DATA_B, edge_byte());
        write_reg(kble_pkg::CFG_REQ_DATA_C, edge_byte());
    endtask

    // Incoming block: length byte, body with echoes, then close or overrun
    function automatic void feed_block(input logic [7:0] length, input bit closing);
        bit started;
        started = 1'b0;
        while (plan_m.phase == kble_pkg::PH_RECEIVE)
        begin
            if (plan_m.skip)
                push_byte(8'($urandom_range(0, 255)));
            else if (plan_m.pos == 8'd0)
            begin
                if (started)
                    return;
                push_byte(length);
                started = 1'b1;
            end
            else if (plan_m.pos == plan_m.len)
                push_byte(closing ? kble_pkg::BYTE_END : other_than(kble_pkg::BYTE_END));
            else
                push_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    // Outgoing request: own echo, stray bytes, complement, closing echo
    task automatic feed_request(input bit retune);
        int steps;
        steps = 0;
        while (plan_m.phase == kble_pkg::PH_SEND || plan_m.phase == kble_pkg::PH_CLOSE_ECHO)
        begin
            if (plan_m.phase == kble_pkg::PH_SEND)
            begin
                if ($urandom_range(0, 3) != 0)
                    push_byte(plan_m.pending);
                if ($urandom_range(0, 7) == 0)
                    push_byte(other_than(~plan_m.pending));
                push_byte(~plan_m.pending);
                steps++;
                if (retune && steps == 1)
                begin
                    wait_idle();
                    random_setup();
                end
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    push_byte(other_than(kble_pkg::BYTE_END));
                push_byte(kble_pkg::BYTE_END);
            end
        end
    endtask

    // Sender: offers the next queued byte, holds it until the transfer
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || byte_taken))
        begin
            if (heard_bytes.size() != 0 && (no_gaps() || $urandom_range(0, 99) >= 29))
            begin
                in_valid  <= 1'b1;
                line_byte <= heard_bytes.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off while a backlog waits
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!held_once && n_taken > 250 && n_pushed - n_taken > 8)
            begin
                hold_left = 80;
                held_once = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= no_gaps() || ($urandom_range(0, 99) >= 29);
        end
    end

    // Transfers on both channels: predict on input, compare on output
    always @(posedge clk)
    begin : monitor
        kble_pkg::result_t got;
        kble_pkg::result_t want;
        if (rst_n)
        begin
            byte_taken = in_valid && in_ready;
            if (byte_taken)
            begin
                n_taken++;
                want = step_link(chk_m, line_byte);
                due_results.push_back(want);
                n_blocks   += want.block_done;
                n_requests += want.request_sent;
                n_overruns += want.framing_error;
            end
            if (out_valid && out_ready)
            begin
                n_results++;
                got.send_valid    = send_valid;
                got.send_byte     = send_byte;
                got.payload_valid = payload_valid;
                got.payload_byte  = payload_byte;
                got.payload_index = payload_index;
                got.block_done    = block_done;
                got.block_title   = block_title;
                got.block_counter = block_counter;
                got.request_sent  = request_sent;
                got.framing_error = framing_error;
                got.link_up       = link_up;
                if (due_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("result with nothing outstanding: %s", show(got));
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("mismatch on result %0d", n_results);
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(got));
                        end
                    end
                end
            end
            // watchdog on cycles with no transfer at all
            if (byte_taken || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("no transfer for %0d cycles, giving up", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int roll;
        plan_m = fresh_link();
        chk_m  = fresh_link();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // link start: stray byte, sync answered, stray byte, start
        push_byte(8'h55);
        push_byte(kble_pkg::BYTE_SYNC);
        push_byte(8'hFF);
        push_byte(kble_pkg::BYTE_START);
        // shortest regular block, counter at its top so the request counter wraps
        push_byte(8'd3);
        push_byte(8'hAA);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h5A);
        push_byte(kble_pkg::BYTE_END);
        // request at reset settings, with own echo and stray bytes
        push_byte(plan_m.pending);
        push_byte(~plan_m.pending);
        push_byte(8'h7E);
        push_byte(~plan_m.pending);
        push_byte(~plan_m.pending);
        push_byte(8'h55);
        push_byte(kble_pkg::BYTE_END);
        // zero length block overruns at index one
        push_byte(8'h00);
        push_byte(8'hC3);
        push_byte(8'h12);

        // length above range acts as six; two-byte block closes at index two
        wait_idle();
        write_reg(kble_pkg::CFG_REQ_LENGTH, 8'd7);
        write_reg(kble_pkg::CFG_REQ_TITLE, 8'hFF);
        write_reg(kble_pkg::CFG_REQ_DATA_A, 8'h00);
        write_reg(kble_pkg::CFG_REQ_DATA_B, 8'hFF);
        write_reg(kble_pkg::CFG_REQ_DATA_C, 8'h00);
        push_byte(8'd2);
        push_byte(8'h3C);
        push_byte(8'h80);
        push_byte(8'hC3);
        push_byte(kble_pkg::BYTE_END);
        push_byte(~plan_m.pending);
        // shrinking the length mid-request cuts the bytes still to go
        wait_idle();
        write_reg(kble_pkg::CFG_REQ_LENGTH, 8'd0);
        push_byte(~plan_m.pending);
        push_byte(~plan_m.pending);
        push_byte(kble_pkg::BYTE_END);

        // random exchanges, mostly well formed
        while (n_pushed < RUN_ITEMS)
        begin
            wait_idle();
            if ($urandom_range(0, 3) == 0)
                random_setup();
            case (plan_m.phase)
                kble_pkg::PH_START:
                    push_byte(kble_pkg::BYTE_START);
                kble_pkg::PH_RECEIVE:
                begin
                    roll = $urandom_range(0, 9);
                    if (roll < 7)
                        feed_block(8'(($urandom_range(0, 7) == 0) ? $urandom_range(11, 40)
                                                                  : $urandom_range(1, 10)),
                                   1'b1);
                    else if (roll < 9)
                        feed_block(8'($urandom_range(0, 12)), 1'b0);
                    else
                    begin
                        // stray bytes; one landing on a length position opens a short block
                        repeat ($urandom_range(1, 6))
                        begin
                            if (plan_m.phase == kble_pkg::PH_RECEIVE && !plan_m.skip &&
                                plan_m.pos == 8'd0)
                                push_byte(8'($urandom_range(0, 12)));
                            else
                                push_byte(8'($urandom_range(0, 255)));
                        end
                    end
                end
                default:
                    feed_request($urandom_range(0, 7) == 0);
            endcase
        end

        wait_idle();
        repeat (4) @(posedge clk);
        $display("%0d line bytes, %0d results checked", n_taken, n_results);
        $display("%0d blocks in, %0d requests out, %0d overruns",
                 n_blocks, n_requests, n_overruns);
        if (errors == 0 && due_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
